// ===== rtl/core/chained_hash_key_set_top_defines.svh =====
// Assertion macros used by the RTL controller (chs_ctrl).
`ifndef CHAINED_HASH_KEY_SET_TOP_DEFINES_SVH
`define CHAINED_HASH_KEY_SET_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define CHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define CHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define CHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/chs_pkg.sv =====
`default_nettype none

package chs_pkg;

  localparam int MAX_BUCKETS_DEF      = 16;
  localparam int SLOTS_PER_BUCKET_DEF = 8;

  localparam int KEY_W    = 31;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 5;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 5'd16;

  // remainder unit: 4 key bits per step, key padded to 32 bits
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STEP_W = 3;
  localparam int KEY_PAD_W  = DIV_BITS * DIV_STEPS;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    base_load;
    logic    scan_issue;
    logic    ins_commit;
    logic    rem_commit;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } chs_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  div_done;
    logic  ins_free;
    logic  scan_hit;
    logic  scan_over;
  } chs_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/chs_dp.sv =====
`default_nettype none

module chs_dp
  import chs_pkg::*;
#(
  parameter int MAX_BUCKETS      = MAX_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire chs_cmd_t               cmd,
  output chs_sts_t                    sts,
  input  wire logic [KIND_W-1:0]      in_kind,
  input  wire logic [KEY_W-1:0]       in_key,
  input  wire logic [SIZE_W-1:0]      divisor,
  output logic      [STATUS_W-1:0]    out_status
);

  localparam int TOTAL      = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int ADDR_W     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SLOT_W     = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SLOT_CNT_W = $clog2(SLOTS_PER_BUCKET + 1);

  logic [KEY_W-1:0]      key_r;
  kind_t                 kind_r;
  logic [KEY_PAD_W-1:0]  sh_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [SIZE_W-1:0]     rem_r;
  logic [SIZE_W-1:0]     rem_nxt;
  logic [SIZE_W:0]       div_tmp;

  logic [ADDR_W-1:0]     base_r;
  logic [SLOT_CNT_W-1:0] cnt_r;
  logic                  cnt_done;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_en;
  logic [KEY_W-1:0]      rd_data_r;
  logic                  pv_r;
  logic                  pvld_r;
  logic [ADDR_W-1:0]     paddr_r;

  logic [TOTAL-1:0]            valid_r;
  logic [KEY_W-1:0]            mem [TOTAL];
  logic [SLOTS_PER_BUCKET-1:0] free;
  logic [SLOT_W-1:0]           ins_slot;
  logic [ADDR_W-1:0]           ins_addr;

  status_t               res_r;
  logic [STATUS_W-1:0]   out_status_r;

  // remainder unit: restoring steps, one key bit each
  always_comb begin
    rem_nxt = rem_r;
    div_tmp = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      div_tmp = {rem_nxt, sh_r[KEY_PAD_W-1-b]};
      if (div_tmp >= {1'b0, divisor}) begin
        div_tmp = div_tmp - {1'b0, divisor};
      end
      rem_nxt = div_tmp[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_key;
      kind_r <= kind_t'(in_kind);
      sh_r   <= {{(KEY_PAD_W-KEY_W){1'b0}}, in_key};
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      sh_r  <= sh_r << DIV_BITS;
      rem_r <= rem_nxt;
    end
    if (cmd.base_load) begin
      base_r <= ADDR_W'(rem_r) * ADDR_W'(SLOTS_PER_BUCKET);
    end
    if (cmd.res_set) begin
      res_r <= cmd.res_code;
    end
    if (cmd.out_load) begin
      out_status_r <= res_r;
    end
    if (rd_en) begin
      pvld_r  <= valid_r[rd_addr];
      paddr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      cnt_r  <= '0;
      pv_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + 1'b1;
      end
      if (cmd.base_load) begin
        cnt_r <= '0;
      end else if (rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      pv_r <= rd_en;
    end
  end

  // slot scan: address issued one cycle, compared the next
  assign cnt_done = (cnt_r == SLOT_CNT_W'(SLOTS_PER_BUCKET));
  assign rd_en    = cmd.scan_issue && !cnt_done;
  assign rd_addr  = base_r + ADDR_W'(cnt_r);

  always_comb begin
    free     = '0;
    ins_slot = '0;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      free[s] = !valid_r[base_r + ADDR_W'(s)];
    end
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (free[s]) begin
        ins_slot = SLOT_W'(s);
      end
    end
  end

  assign ins_addr = base_r + ADDR_W'(ins_slot);

  always_ff @(posedge clk) begin
    if (cmd.ins_commit) begin
      mem[ins_addr] <= key_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.ins_commit) begin
      valid_r[ins_addr] <= 1'b1;
    end else if (cmd.rem_commit) begin
      valid_r[paddr_r] <= 1'b0;
    end
  end

  assign sts.kind      = kind_r;
  assign sts.div_done  = (step_r == DIV_STEP_W'(DIV_STEPS - 1));
  assign sts.ins_free  = |free;
  assign sts.scan_hit  = pv_r && pvld_r && (rd_data_r == key_r);
  assign sts.scan_over = cnt_done && !pv_r;

  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/core/chs_ctrl.sv =====
`default_nettype none

`include "chained_hash_key_set_top_defines.svh"

module chs_ctrl
  import chs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire chs_sts_t sts,
  output chs_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_BASE,
    S_INS,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.res_code  = STATUS_MISSING;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        cmd.base_load = 1'b1;
        case (sts.kind) inside
          KIND_INSERT: state_nxt = S_INS;
          KIND_REMOVE, KIND_SEARCH: state_nxt = S_SCAN;
          default: begin
            cmd.res_set = 1'b1;
            state_nxt   = S_FIN;
          end
        endcase
      end
      S_INS: begin
        cmd.res_set    = 1'b1;
        cmd.res_code   = sts.ins_free ? STATUS_OK : STATUS_FULL;
        cmd.ins_commit = sts.ins_free;
        state_nxt      = S_FIN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_hit) begin
          cmd.res_set    = 1'b1;
          cmd.res_code   = STATUS_OK;
          cmd.rem_commit = (sts.kind == KIND_REMOVE);
          state_nxt      = S_FIN;
        end else if (sts.scan_over) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `CHS_ASSERT_NXT(a_accept_starts_div, clk, rst_n, in_tvalid && in_tready, state_r == S_DIV)
  `CHS_ASSERT_IMP(a_remove_hit_clears, clk, rst_n,
                  state_r == S_SCAN && sts.scan_hit && sts.kind == KIND_REMOVE, cmd.rem_commit)
  `CHS_ASSERT_IMP(a_insert_needs_free, clk, rst_n, cmd.ins_commit, sts.ins_free)
  `CHS_ASSERT_NXT(a_load_shows_beat, clk, rst_n, cmd.out_load, out_valid_r)

endmodule

`default_nettype wire

// ===== rtl/core/chained_hash_key_set_top.sv =====
`default_nettype none

// Keyed set of 31-bit keys kept in MAX_BUCKETS buckets of SLOTS_PER_BUCKET
// slots. Each input beat (tuser = kind: insert, remove, search; tdata = key)
// gives one output beat with the status. The bucket is key modulo
// table_size (register at byte 0; 0 acts as 1, values above MAX_BUCKETS
// saturate). One item is in work at a time. From accept to result: the
// remainder unit (4 key bits per cycle), then forming the bucket base,
// then an insert step, or for remove/search one slot read per cycle
// from the key memory until a hit or the end of the bucket, then the
// output register (held while the last status beat waits) and back
// to ready. Valid bits clear at reset; no clearing pass is needed.
module chained_hash_key_set_top
  import chs_pkg::*;
#(
  parameter int MAX_BUCKETS      = MAX_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,   // [30:0] key
  input  wire logic [KIND_W-1:0]       in_tuser,   // [1:0] kind
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic      [OUT_TDATA_W-1:0]  out_tdata,  // [1:0] status
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  logic [SIZE_W-1:0]   table_size_r;
  logic [SIZE_W-1:0]   eff_size;
  logic                cfg_wr;
  logic                cfg_hit;
  logic [STATUS_W-1:0] out_status;
  chs_cmd_t            cmd;
  chs_sts_t            sts;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1] == REG_TABLE_SIZE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RST;
    end else if (cfg_wr && cfg_hit) begin
      table_size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? {{(CFG_DATA_W-SIZE_W){1'b0}}, table_size_r} : '0;

  always_comb begin
    if (table_size_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(table_size_r) > MAX_BUCKETS) begin
      eff_size = SIZE_W'(MAX_BUCKETS);
    end else begin
      eff_size = table_size_r;
    end
  end

  chs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  chs_dp #(
    .MAX_BUCKETS      (MAX_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_key     (in_tdata[KEY_W-1:0]),
    .divisor    (eff_size),
    .out_status (out_status)
  );

  assign out_tdata = {{(OUT_TDATA_W-STATUS_W){1'b0}}, out_status};

endmodule

`default_nettype wire

// ===== test/key_set_checker.sv =====
module key_set_checker
  import chs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [30:0] key
  input  wire logic [KIND_W-1:0]      in_tuser,   // [1:0] kind
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,  // [1:0] status
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic                   cfg_pready,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  input  wire logic [CFG_DATA_W-1:0]  cfg_prdata,
  output int                          errors,
  output int                          pending,
  output int                          full_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = MAX_BUCKETS_DEF * SLOTS_PER_BUCKET_DEF;

  logic [KEY_W-1:0]  slot_key  [SLOTS];
  logic              slot_used [SLOTS];
  logic [SIZE_W-1:0] table_size;
  status_t           status_due [$];

  initial begin
    errors     = 0;
    pending    = 0;
    full_count = 0;
    table_size = TABLE_SIZE_RST;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
  end

  function automatic status_t apply_table_op(input logic [KIND_W-1:0] kind,
                                             input logic [KEY_W-1:0] key);
    int unsigned span;
    int unsigned base;
    int unsigned hit;
    status_t     st;
    span = (table_size == 0) ? 1 :
           (table_size > MAX_BUCKETS_DEF) ? MAX_BUCKETS_DEF : table_size;
    base = (key % span) * SLOTS_PER_BUCKET_DEF;
    hit  = SLOTS;
    st   = STATUS_MISSING;
    for (int s = 0; s < SLOTS_PER_BUCKET_DEF; s++) begin
      if (hit == SLOTS && slot_used[base+s] && slot_key[base+s] == key) hit = base + s;
    end
    case (kind)
      KIND_INSERT: begin
        st = STATUS_FULL;
        for (int s = 0; s < SLOTS_PER_BUCKET_DEF; s++) begin
          if (st == STATUS_FULL && !slot_used[base+s]) begin
            slot_used[base+s] = 1'b1;
            slot_key[base+s]  = key;
            st = STATUS_OK;
          end
        end
      end
      KIND_REMOVE: begin
        if (hit != SLOTS) begin
          slot_used[hit] = 1'b0;
          st = STATUS_OK;
        end
      end
      KIND_SEARCH: begin
        if (hit != SLOTS) st = STATUS_OK;
      end
      default: st = STATUS_MISSING;
    endcase
    return st;
  endfunction

  always @(posedge clk) begin
    status_t exp_st;
    if (!rst_n) begin
      table_size = TABLE_SIZE_RST;
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      status_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if ((cfg_paddr >> 2) == REG_TABLE_SIZE) table_size = cfg_pwdata[SIZE_W-1:0];
        end else if ((cfg_paddr >> 2) == REG_TABLE_SIZE) begin
          if (cfg_prdata !== CFG_DATA_W'(table_size)) begin
            errors++;
            $display("%0t: table_size read expected %0d actual %0d",
                     $time, table_size, cfg_prdata);
          end
        end
      end
      if (out_tvalid && out_tready) begin
        if (status_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected status beat, expected none actual %0d",
                   $time, out_tdata);
        end else begin
          exp_st = status_due.pop_front();
          if (out_tdata !== OUT_TDATA_W'(exp_st)) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp_st, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        exp_st = apply_table_op(in_tuser, in_tdata[KEY_W-1:0]);
        if (exp_st == STATUS_FULL) full_count++;
        status_due = {status_due, exp_st};
      end
    end
    pending = status_due.size();
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import chs_pkg::*;

  localparam logic [KIND_W-1:0]     KIND_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TABLE_SIZE = CFG_ADDR_W'(REG_TABLE_SIZE) << 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
  localparam int POOL = 20;
  localparam int PHASES = 7;
  localparam int PHASE_OPS = 200;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [30:0] key
  logic [KIND_W-1:0]      in_tuser = '0;   // [1:0] kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [1:0] status
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int errors;
  int pending;
  int full_count;
  int sent = 0;
  int settings = 1;
  bit quiet = 1'b0;
  logic [KEY_W-1:0] key_pool [POOL];

  chained_hash_key_set_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  key_set_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .errors(errors), .pending(pending), .full_count(full_count)
  );

  always #10 clk = ~clk;

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(key);
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  // drop valid and wait until every status beat is back
  task automatic settle(input int tail);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] draw_key();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return key_pool[$urandom_range(0, POOL-1)];
      6:       return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 3));
      7:       return KEY_W'($urandom_range(0, 40));
      default: return r[KEY_W-1:0];
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] draw_kind();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return KIND_INSERT;
    if (p < 65) return KIND_REMOVE;
    if (p < 95) return KIND_SEARCH;
    return KIND_UNUSED;
  endfunction

  initial begin
    logic [31:0]       r;
    logic [SIZE_W-1:0] sizes [PHASES];
    sizes = '{5'd1, 5'd0, 5'd31, 5'd7, 5'd17, 5'd16, 5'd16};
    sizes[PHASES-1] = SIZE_W'($urandom_range(1, 16));
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset table size of 16
    send_op(KIND_INSERT, '0);
    send_op(KIND_INSERT, {KEY_W{1'b1}});
    send_op(KIND_SEARCH, {KEY_W{1'b1}});
    send_op(KIND_UNUSED, {KEY_W{1'b1}});
    send_op(KIND_SEARCH, {KEY_W{1'b1}});
    send_op(KIND_REMOVE, '0);
    send_op(KIND_REMOVE, '0);
    send_op(KIND_SEARCH, '0);
    for (int i = 0; i < 9; i++) send_op(KIND_INSERT, KEY_W'(5 + 16 * i));
    send_op(KIND_SEARCH, KEY_W'(53));
    send_op(KIND_REMOVE, KEY_W'(53));
    send_op(KIND_INSERT, KEY_W'(53));
    send_op(KIND_INSERT, 31'h5555_5555);
    send_op(KIND_SEARCH, 31'h2AAA_AAAA);
    send_op(KIND_REMOVE, {KEY_W{1'b1}});

    for (int ph = 0; ph < PHASES; ph++) begin
      settle(30);
      cfg_access(1'b1, ADDR_TABLE_SIZE, CFG_DATA_W'(sizes[ph]));
      if (ph == 3) cfg_access(1'b1, ADDR_UNMAPPED, 32'd3);
      cfg_access(1'b0, ADDR_TABLE_SIZE, '0);
      settings++;
      for (int i = 0; i < POOL; i++) begin
        r = $urandom();
        key_pool[i] = (i % 2 == 0) ? KEY_W'(i % 4 + 16 * $urandom_range(0, 1000))
                                   : r[KEY_W-1:0];
      end
      for (int n = 0; n < PHASE_OPS; n++) begin
        if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (ph == 2 && n == 100) settle(0);
        send_op(draw_kind(), draw_key());
      end
    end

    settle(30);
    $display("Ran %0d table operations over %0d table-size settings; %0d inserts hit a full bucket.",
             sent, settings, full_count);
    $display("Both channels saw random gaps and back-pressure, with full-rate stretches.");
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
